[hw/rtl/mrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and codes of the maxrects rectangle packer.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int IDX_BITS  = 2;
	localparam int DATA_BITS = 16;

	localparam logic CMD_START = 1'b0;

	localparam logic [1:0] ST_PLACED = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_NOFIT  = 2'd2;

	localparam logic [2:0] HEUR_FIRST = 3'd0;
	localparam logic [2:0] HEUR_TL    = 3'd1;
	localparam logic [2:0] HEUR_AREA  = 3'd2;
	localparam logic [2:0] HEUR_SHORT = 3'd3;
	localparam logic [2:0] HEUR_LONG  = 3'd4;
	localparam logic [2:0] HEUR_MINW  = 3'd5;
	localparam logic [2:0] HEUR_MINH  = 3'd6;

	localparam logic [IDX_BITS-1:0] REG_BIN_W = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_BIN_H = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_HEUR  = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_ROT   = 2'd3;

	localparam logic [15:0] BIN_RESET  = 16'd1024;
	localparam logic [2:0]  HEUR_RESET = HEUR_AREA;
	localparam logic        ROT_RESET  = 1'b1;

	localparam int NEIGHBOUR_BONUS = 5;
	localparam int EDGE_BONUS      = 1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        was_rotated;
		logic        overflow;
	} rsp_t;

endpackage

[hw/rtl/maxrects_rect_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxrects_rect_packer
// MaxRects packer for one bin: free list and placed list in synchronous
// memories, scanned, split, pruned and compacted by one sequencer.
//
//   channel   signals                                  moves
//   req       req_valid / req_ready / req              start or insert request
//   rsp       rsp_valid / rsp_ready / rsp              one result per request
//   cfg       cfg_valid / cfg_ready / cfg_index,data   register write
//
// start and zero-size requests: result goes straight to S_DONE, no scan
// insert: scan of the free entries (top-left also reads each placed entry
//   for each fitting one), placement, split of every overlapped entry,
//   pruning over slots and slot pairs, then compaction of the slots; all
//   steps share the one read port of the free-list memory
// after reset the S_INIT state loads the full bin into entry zero before req_ready
// a finished result waits in the rsp register while the next request is taken
// ----------------------------------------------------------------------------
module maxrects_rect_packer
	import mrp_pkg::*;
#(
	parameter int FREE_DEPTH   = 64,
	parameter int PLACED_DEPTH = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_BITS-1:0]  cfg_index,
	input  logic [DATA_BITS-1:0] cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int XW    = CB + 1;
	localparam int SW    = 2 * CB + 3;
	localparam int SLOTS = 2 * FREE_DEPTH;
	localparam int SA    = $clog2(SLOTS);
	localparam int ST    = $clog2(SLOTS + 1);
	localparam int FC    = $clog2(FREE_DEPTH + 1);
	localparam int PA    = $clog2(PLACED_DEPTH);
	localparam int PC    = $clog2(PLACED_DEPTH + 1);

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] w;
		logic [CB-1:0] h;
	} box_t;

	typedef struct packed {
		logic dead;
		box_t b;
	} slot_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_TL_RD, S_TL_EV, S_TL_END,
		S_SCAN_CMP, S_PLACE, S_PUSH, S_SPL_RD, S_SPL_EV, S_PR_RDA, S_PR_EVA,
		S_PR_RDB, S_PR_EVB, S_CMP_RD, S_CMP_EV, S_DONE
	} state_t;

	function automatic logic [XW-1:0] right_of(box_t r);
		return XW'(r.x) + XW'(r.w);
	endfunction

	function automatic logic [XW-1:0] bottom_of(box_t r);
		return XW'(r.y) + XW'(r.h);
	endfunction

	function automatic logic overlaps(box_t a, box_t b);
		logic nz;
		nz = (a.w != '0) && (a.h != '0) && (b.w != '0) && (b.h != '0);
		return nz && (XW'(a.x) < right_of(b)) && (XW'(b.x) < right_of(a)) &&
			(XW'(a.y) < bottom_of(b)) && (XW'(b.y) < bottom_of(a));
	endfunction

	function automatic logic holds(box_t outer, box_t inr);
		return (inr.x >= outer.x) && (inr.y >= outer.y) &&
			(right_of(inr) <= right_of(outer)) && (bottom_of(inr) <= bottom_of(outer));
	endfunction

	// memories
	slot_t fmem [SLOTS];
	box_t  pmem [PLACED_DEPTH];

	logic          f_we;
	logic [SA-1:0] f_waddr;
	slot_t         f_wdata;
	logic [SA-1:0] f_raddr;
	slot_t         f_rdata_q;
	logic          p_we;
	logic [PA-1:0] p_waddr;
	logic [PA-1:0] p_raddr;
	box_t          p_rdata_q;

	always_ff @(posedge clk) begin
		if (f_we)
			fmem[f_waddr] <= f_wdata;
		f_rdata_q <= fmem[f_raddr];
	end

	// control and working registers
	state_t         state_q;
	logic [CB-1:0]  bin_w_q, bin_h_q;
	logic [2:0]     heur_q;
	logic           rot_en_q;
	logic [FC-1:0]  fcount_q, live_q;
	logic [PC-1:0]  pcount_q, pk_q;
	logic [ST-1:0]  idx_q, jdx_q, tail_q;
	logic [CB-1:0]  pw_q, ph_q;
	box_t           cur_q;
	logic           cur_rot_q;
	logic [SW-1:0]  term_q, tl_acc_q, best_score_q;
	logic           tl_l_q, tl_r_q;
	logic           have_best_q;
	logic [SA-1:0]  best_idx_q;
	logic           best_rot_q, best_l_q, best_r_q;
	box_t           best_f_q, pl_q, a_q;
	logic           drop_q;
	box_t           cand_q [4];
	logic [3:0]     cand_en_q;
	logic [1:0]     cc_q;
	state_t         push_ret_q;
	rsp_t           res_q, rsp_q;
	logic           rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// scan datapath
	box_t            fr;
	logic            fit_straight, fit_turned, use_rot;
	logic [CB-1:0]   use_w, use_h, dw, dh;
	logic [2*CB-1:0] area_c;
	logic [SW-1:0]   term_c, score_c;
	logic            better;

	assign fr = f_rdata_q.b;

	always_comb begin
		fit_straight = (fr.w >= pw_q) && (fr.h >= ph_q);
		fit_turned   = (fr.w >= ph_q) && (fr.h >= pw_q);
		use_rot      = !fit_straight;
		use_w        = use_rot ? ph_q : pw_q;
		use_h        = use_rot ? pw_q : ph_q;
		dw           = fr.w - use_w;
		dh           = fr.h - use_h;
		area_c       = fr.w * fr.h;
		case (heur_q)
			HEUR_AREA:  term_c = SW'(area_c);
			HEUR_SHORT: term_c = SW'((dw < dh) ? dw : dh);
			HEUR_LONG:  term_c = SW'((dw > dh) ? dw : dh);
			HEUR_MINW:  term_c = SW'(fr.w);
			HEUR_MINH:  term_c = SW'(fr.h);
			default:    term_c = '0;
		endcase
		score_c = (cur_rot_q ? SW'(pw_q) : SW'(0)) + term_q;
		better  = !have_best_q || ($signed(score_c) < $signed(best_score_q));
	end

	// top-left neighbour test
	box_t          pr;
	logic [XW-1:0] pmid, fmid, mid_gap;
	logic [CB-1:0] lim;
	logic          near, hit_l, hit_r;
	logic [SW-1:0] nb_dec;
	logic          bnd_ok, bnd_r, bnd_l;

	assign pr = p_rdata_q;

	always_comb begin
		pmid    = XW'(pr.y) + XW'(pr.h >> 1);
		fmid    = XW'(cur_q.y) + XW'(cur_q.h >> 1);
		mid_gap = (pmid >= fmid) ? (pmid - fmid) : (fmid - pmid);
		lim     = ((pr.h > cur_q.h) ? pr.h : cur_q.h) >> 1;
		near    = mid_gap < XW'(lim);
		hit_l   = near && (right_of(pr) == XW'(cur_q.x));
		hit_r   = near && (XW'(pr.x) == right_of(cur_q));
		nb_dec  = (hit_l ? SW'(NEIGHBOUR_BONUS) : SW'(0)) +
			(hit_r ? SW'(NEIGHBOUR_BONUS) : SW'(0));
		bnd_ok  = tl_l_q || !tl_r_q;
		bnd_r   = bnd_ok && (right_of(cur_q) == XW'(bin_w_q));
		bnd_l   = bnd_ok && (cur_q.x == '0);
	end

	// placement and split candidates
	logic [CB-1:0] pl_w, pl_h;
	logic          shift_right;
	box_t          pl_next_c;
	box_t          place_c [2];
	logic [1:0]    place_en;
	box_t          split_c [4];
	logic [3:0]    split_en;
	logic          spl_hit, hold_ba, hold_ab, push_ok;

	always_comb begin
		pl_w        = best_rot_q ? ph_q : pw_q;
		pl_h        = best_rot_q ? pw_q : ph_q;
		shift_right = (heur_q == HEUR_TL) && !best_l_q &&
			(((best_f_q.x != '0) && (right_of(best_f_q) == XW'(bin_w_q))) || best_r_q);
		pl_next_c.x = shift_right ? CB'(right_of(best_f_q) - XW'(pl_w)) : best_f_q.x;
		pl_next_c.y = best_f_q.y;
		pl_next_c.w = pl_w;
		pl_next_c.h = pl_h;

		place_en[0] = best_f_q.w > pl_w;
		place_c[0]  = '{x: best_f_q.x + ((pl_next_c.x == best_f_q.x) ? pl_w : '0),
			y: best_f_q.y, w: best_f_q.w - pl_w, h: best_f_q.h};
		place_en[1] = best_f_q.h > pl_h;
		place_c[1]  = '{x: best_f_q.x, y: best_f_q.y + pl_h, w: best_f_q.w,
			h: best_f_q.h - pl_h};

		split_en[0] = right_of(pl_q) < right_of(fr);
		split_c[0]  = '{x: CB'(right_of(pl_q)), y: fr.y,
			w: CB'(right_of(fr) - right_of(pl_q)), h: fr.h};
		split_en[1] = bottom_of(pl_q) < bottom_of(fr);
		split_c[1]  = '{x: fr.x, y: CB'(bottom_of(pl_q)), w: fr.w,
			h: CB'(bottom_of(fr) - bottom_of(pl_q))};
		split_en[2] = pl_q.x > fr.x;
		split_c[2]  = '{x: fr.x, y: fr.y, w: pl_q.x - fr.x, h: fr.h};
		split_en[3] = pl_q.y > fr.y;
		split_c[3]  = '{x: fr.x, y: fr.y, w: fr.w, h: pl_q.y - fr.y};

		spl_hit = !f_rdata_q.dead && overlaps(fr, pl_q);
		hold_ba = holds(fr, a_q);
		hold_ab = holds(a_q, fr);
		push_ok = live_q < FC'(FREE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (p_we)
			pmem[p_waddr] <= pl_next_c;
		p_rdata_q <= pmem[p_raddr];
	end

	// memory port control
	always_comb begin
		f_we    = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		f_raddr = idx_q[SA-1:0];
		p_we    = 1'b0;
		p_waddr = pcount_q[PA-1:0];
		p_raddr = pk_q[PA-1:0];
		case (state_q)
			S_INIT: begin
				f_we    = 1'b1;
				f_wdata = '{dead: 1'b0, b: '{x: '0, y: '0, w: CB'(BIN_RESET),
					h: CB'(BIN_RESET)}};
			end
			S_IDLE: begin
				if (req_valid && req.cmd == CMD_START) begin
					f_we    = 1'b1;
					f_wdata = '{dead: 1'b0, b: '{x: '0, y: '0, w: bin_w_q, h: bin_h_q}};
				end
			end
			S_PLACE: begin
				f_we    = 1'b1;
				f_waddr = best_idx_q;
				f_wdata = '{dead: 1'b1, b: best_f_q};
				p_we    = pcount_q < PC'(PLACED_DEPTH);
			end
			S_PUSH: begin
				f_we    = cand_en_q[cc_q] && push_ok;
				f_waddr = tail_q[SA-1:0];
				f_wdata = '{dead: 1'b0, b: cand_q[cc_q]};
			end
			S_SPL_EV: begin
				f_we    = spl_hit;
				f_waddr = idx_q[SA-1:0];
				f_wdata = '{dead: 1'b1, b: fr};
			end
			S_PR_RDB: begin
				f_raddr = jdx_q[SA-1:0];
			end
			S_PR_EVB: begin
				if (!f_rdata_q.dead && hold_ba) begin
					f_we    = 1'b1;
					f_waddr = idx_q[SA-1:0];
					f_wdata = '{dead: 1'b1, b: a_q};
				end else if (!f_rdata_q.dead && hold_ab) begin
					f_we    = 1'b1;
					f_waddr = jdx_q[SA-1:0];
					f_wdata = '{dead: 1'b1, b: fr};
				end
			end
			S_CMP_EV: begin
				f_we    = !f_rdata_q.dead;
				f_waddr = jdx_q[SA-1:0];
				f_wdata = '{dead: 1'b0, b: fr};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			bin_w_q      <= CB'(BIN_RESET);
			bin_h_q      <= CB'(BIN_RESET);
			heur_q       <= HEUR_RESET;
			rot_en_q     <= ROT_RESET;
			fcount_q     <= FC'(1);
			live_q       <= '0;
			pcount_q     <= '0;
			pk_q         <= '0;
			idx_q        <= '0;
			jdx_q        <= '0;
			tail_q       <= '0;
			pw_q         <= '0;
			ph_q         <= '0;
			cur_q        <= '0;
			cur_rot_q    <= 1'b0;
			term_q       <= '0;
			tl_acc_q     <= '0;
			best_score_q <= '0;
			tl_l_q       <= 1'b0;
			tl_r_q       <= 1'b0;
			have_best_q  <= 1'b0;
			best_idx_q   <= '0;
			best_rot_q   <= 1'b0;
			best_l_q     <= 1'b0;
			best_r_q     <= 1'b0;
			best_f_q     <= '0;
			pl_q         <= '0;
			a_q          <= '0;
			drop_q       <= 1'b0;
			for (int k = 0; k < 4; k++)
				cand_q[k] <= '0;
			cand_en_q    <= '0;
			cc_q         <= '0;
			push_ret_q   <= S_SPL_RD;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_BIN_W: bin_w_q  <= cfg_data[CB-1:0];
					REG_BIN_H: bin_h_q  <= cfg_data[CB-1:0];
					REG_HEUR:  heur_q   <= cfg_data[2:0];
					REG_ROT:   rot_en_q <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (rsp_valid_q && rsp_ready && state_q != S_DONE)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						drop_q <= 1'b0;
						pw_q   <= req.rect_width[CB-1:0];
						ph_q   <= req.rect_height[CB-1:0];
						if (req.cmd == CMD_START) begin
							fcount_q <= FC'(1);
							pcount_q <= '0;
							res_q    <= '{status: ST_PLACED, pos_x: '0, pos_y: '0,
								was_rotated: 1'b0, overflow: 1'b0};
							state_q  <= S_DONE;
						end else if (req.rect_width[CB-1:0] == '0 ||
							req.rect_height[CB-1:0] == '0) begin
							res_q   <= '{status: ST_ZERO, pos_x: '0, pos_y: '0,
								was_rotated: 1'b0, overflow: 1'b0};
							state_q <= S_DONE;
						end else begin
							idx_q       <= '0;
							have_best_q <= 1'b0;
							state_q     <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == ST'(fcount_q)) begin
						if (have_best_q) begin
							state_q <= S_PLACE;
						end else begin
							res_q   <= '{status: ST_NOFIT, pos_x: '1, pos_y: '1,
								was_rotated: 1'b0, overflow: 1'b0};
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					cur_q     <= fr;
					cur_rot_q <= use_rot;
					term_q    <= term_c;
					tl_acc_q  <= SW'(fr.y);
					tl_l_q    <= 1'b0;
					tl_r_q    <= 1'b0;
					pk_q      <= '0;
					if (!(fit_straight || fit_turned) || (use_rot && !rot_en_q)) begin
						idx_q   <= idx_q + ST'(1);
						state_q <= S_SCAN_RD;
					end else if (heur_q == HEUR_FIRST) begin
						best_idx_q <= idx_q[SA-1:0];
						best_rot_q <= use_rot;
						best_l_q   <= 1'b0;
						best_r_q   <= 1'b0;
						best_f_q   <= fr;
						state_q    <= S_PLACE;
					end else if (heur_q == HEUR_TL) begin
						state_q <= (pcount_q == '0) ? S_TL_END : S_TL_RD;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_TL_RD: begin
					state_q <= S_TL_EV;
				end
				S_TL_EV: begin
					tl_acc_q <= tl_acc_q - nb_dec;
					if (hit_l)
						tl_l_q <= 1'b1;
					if (hit_r)
						tl_r_q <= 1'b1;
					pk_q    <= pk_q + PC'(1);
					state_q <= (pk_q + PC'(1) == pcount_q) ? S_TL_END : S_TL_RD;
				end
				S_TL_END: begin
					term_q <= tl_acc_q - (bnd_r ? SW'(EDGE_BONUS) : SW'(0)) -
						(bnd_l ? SW'(EDGE_BONUS) : SW'(0));
					if (bnd_r)
						tl_r_q <= 1'b1;
					if (bnd_l)
						tl_l_q <= 1'b1;
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (better) begin
						have_best_q  <= 1'b1;
						best_score_q <= score_c;
						best_idx_q   <= idx_q[SA-1:0];
						best_rot_q   <= cur_rot_q;
						best_l_q     <= tl_l_q;
						best_r_q     <= tl_r_q;
						best_f_q     <= cur_q;
					end
					idx_q   <= idx_q + ST'(1);
					state_q <= S_SCAN_RD;
				end
				S_PLACE: begin
					pl_q <= pl_next_c;
					if (pcount_q < PC'(PLACED_DEPTH))
						pcount_q <= pcount_q + PC'(1);
					else
						drop_q <= 1'b1;
					live_q     <= fcount_q - FC'(1);
					tail_q     <= ST'(fcount_q);
					cand_q[0]  <= place_c[0];
					cand_q[1]  <= place_c[1];
					cand_en_q  <= {2'b00, place_en};
					cc_q       <= '0;
					idx_q      <= '0;
					push_ret_q <= S_SPL_RD;
					state_q    <= S_PUSH;
				end
				S_PUSH: begin
					if (cand_en_q[cc_q]) begin
						if (push_ok) begin
							tail_q <= tail_q + ST'(1);
							live_q <= live_q + FC'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
					cc_q <= cc_q + 2'd1;
					if (cc_q == 2'd3)
						state_q <= push_ret_q;
				end
				S_SPL_RD: begin
					if (idx_q == ST'(fcount_q)) begin
						idx_q   <= '0;
						state_q <= S_PR_RDA;
					end else begin
						state_q <= S_SPL_EV;
					end
				end
				S_SPL_EV: begin
					idx_q <= idx_q + ST'(1);
					if (spl_hit) begin
						live_q    <= live_q - FC'(1);
						for (int k = 0; k < 4; k++)
							cand_q[k] <= split_c[k];
						cand_en_q <= split_en;
						cc_q      <= '0;
						state_q   <= S_PUSH;
					end else begin
						state_q <= S_SPL_RD;
					end
				end
				S_PR_RDA: begin
					if (idx_q == tail_q) begin
						idx_q   <= '0;
						jdx_q   <= '0;
						state_q <= S_CMP_RD;
					end else begin
						state_q <= S_PR_EVA;
					end
				end
				S_PR_EVA: begin
					if (f_rdata_q.dead) begin
						idx_q   <= idx_q + ST'(1);
						state_q <= S_PR_RDA;
					end else begin
						a_q     <= fr;
						jdx_q   <= idx_q + ST'(1);
						state_q <= S_PR_RDB;
					end
				end
				S_PR_RDB: begin
					if (jdx_q == tail_q) begin
						idx_q   <= idx_q + ST'(1);
						state_q <= S_PR_RDA;
					end else begin
						state_q <= S_PR_EVB;
					end
				end
				S_PR_EVB: begin
					if (!f_rdata_q.dead && hold_ba) begin
						idx_q   <= idx_q + ST'(1);
						state_q <= S_PR_RDA;
					end else begin
						jdx_q   <= jdx_q + ST'(1);
						state_q <= S_PR_RDB;
					end
				end
				S_CMP_RD: begin
					if (idx_q == tail_q) begin
						fcount_q <= FC'(jdx_q);
						res_q    <= '{status: ST_PLACED, pos_x: 16'(pl_q.x),
							pos_y: 16'(pl_q.y), was_rotated: best_rot_q, overflow: drop_q};
						state_q  <= S_DONE;
					end else begin
						state_q <= S_CMP_EV;
					end
				end
				S_CMP_EV: begin
					if (!f_rdata_q.dead)
						jdx_q <= jdx_q + ST'(1);
					idx_q   <= idx_q + ST'(1);
					state_q <= S_CMP_RD;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fcount_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= FC'(FREE_DEPTH))
		else $error("free count above capacity");

	a_tail_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= ST'(SLOTS))
		else $error("slot tail above storage");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP_EV |-> jdx_q <= idx_q)
		else $error("compaction write pointer passed read pointer");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done state");

endmodule

[bench/maxrects_rect_packer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxrects_rect_packer_tb
// Self-checking bench for the maxrects packer. A directed table covers reset
// defaults, zero-size and oversized pieces, a full-bin fill and a rotated
// fit. Random phases then rewrite every register, open a bin and insert
// pieces. Each accepted request is run through a local packing model, and
// results are compared field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module maxrects_rect_packer_tb
	import mrp_pkg::*;
();

	localparam int FREE_DEPTH   = 64;
	localparam int PLACED_DEPTH = 64;
	localparam int TOTAL_REQS   = 1170;

	typedef struct {
		int unsigned x, y, w, h;
	} box_t;

	typedef struct {
		logic        cmd;
		logic [15:0] w;
		logic [15:0] h;
		bit          fixed;
		rsp_t        exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_BITS-1:0]  cfg_index;
	logic [DATA_BITS-1:0] cfg_data;

	box_t free_list[FREE_DEPTH];
	int   free_num;
	box_t placed_list[PLACED_DEPTH];
	int   placed_num;
	bit   dropped;
	int unsigned bin_w, bin_h, heur, rot_en;

	rsp_t placement_q[$];
	int   errors;
	int   sent;
	bit   send_busy_mode;
	bit   recv_busy_mode;

	maxrects_rect_packer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void drop_free(int i);
		for (int k = i; k < free_num - 1; k++) free_list[k] = free_list[k + 1];
		free_num--;
	endfunction

	function automatic void add_free(box_t b);
		if (free_num < FREE_DEPTH) begin
			free_list[free_num] = b;
			free_num++;
		end else begin
			dropped = 1;
		end
	endfunction

	function automatic bit boxes_overlap(box_t a, box_t b);
		if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0) return 0;
		return a.x < b.x + b.w && b.x < a.x + a.w && a.y < b.y + b.h && b.y < a.y + a.h;
	endfunction

	function automatic bit box_holds(box_t o, box_t n);
		return n.x >= o.x && n.y >= o.y && n.x + n.w <= o.x + o.w &&
			n.y + n.h <= o.y + o.h;
	endfunction

	function automatic void open_bin();
		free_list[0] = '{0, 0, bin_w, bin_h};
		free_num = 1;
		placed_num = 0;
	endfunction

	function automatic longint touch_score(box_t f, output bit l, output bit r);
		longint m, fmid, d, lim;
		box_t p;
		m = f.y;
		fmid = longint'(f.y) + longint'(f.h / 2);
		l = 0;
		r = 0;
		for (int k = 0; k < placed_num; k++) begin
			p = placed_list[k];
			d = longint'(p.y) + longint'(p.h / 2) - fmid;
			lim = (p.h > f.h ? p.h : f.h) / 2;
			if (d < 0) d = -d;
			if (d < lim) begin
				if (p.x + p.w == f.x) begin
					m -= NEIGHBOUR_BONUS;
					l = 1;
				end
				if (p.x == f.x + f.w) begin
					m -= NEIGHBOUR_BONUS;
					r = 1;
				end
			end
		end
		if (l || !r) begin
			if (f.x + f.w == bin_w) begin
				m -= EDGE_BONUS;
				r = 1;
			end
			if (f.x == 0) begin
				m -= EDGE_BONUS;
				l = 1;
			end
		end
		return m;
	endfunction

	function automatic rsp_t pack_piece(req_t rq);
		rsp_t o;
		int unsigned pw, ph, w, h, sw, sh;
		longint best, m;
		int bi, i, j;
		bit bl, br, brot, l, r, rot, straight, turned, gone;
		box_t f, p, q, n;
		o = '0;
		dropped = 0;
		pw = rq.rect_width;
		ph = rq.rect_height;
		best = 64'h7FFF_FFFF_FFFF_FFFF;
		bi = -1;
		bl = 0;
		br = 0;
		brot = 0;
		if (rq.cmd == CMD_START) begin
			open_bin();
			return o;
		end
		if (pw == 0 || ph == 0) begin
			o.status = ST_ZERO;
			return o;
		end
		for (i = 0; i < free_num; i++) begin
			f = free_list[i];
			w = pw;
			h = ph;
			m = 0;
			rot = 0;
			l = 0;
			r = 0;
			straight = f.w >= pw && f.h >= ph;
			turned = f.w >= ph && f.h >= pw;
			if (!straight && !turned) continue;
			if (!straight) begin
				if (!rot_en) continue;
				w = ph;
				h = pw;
				rot = 1;
				m += h;
			end
			if (heur == HEUR_FIRST) begin
				bi = i;
				brot = rot;
				break;
			end
			case (heur)
				HEUR_TL: m += touch_score(f, l, r);
				HEUR_AREA: m += longint'(f.w) * longint'(f.h);
				HEUR_SHORT: m += (f.w - w < f.h - h) ? f.w - w : f.h - h;
				HEUR_LONG: m += (f.w - w > f.h - h) ? f.w - w : f.h - h;
				HEUR_MINW: m += f.w;
				HEUR_MINH: m += f.h;
				default: ;
			endcase
			if (m < best) begin
				best = m;
				bi = i;
				bl = l;
				br = r;
				brot = rot;
			end
		end
		if (bi < 0) begin
			o.status = ST_NOFIT;
			o.pos_x = '1;
			o.pos_y = '1;
			return o;
		end
		sw = brot ? ph : pw;
		sh = brot ? pw : ph;
		f = free_list[bi];
		p = '{f.x, f.y, sw, sh};
		if (heur == HEUR_TL && !bl && ((f.x != 0 && f.x + f.w == bin_w) || br))
			p.x = f.x + f.w - sw;
		if (placed_num < PLACED_DEPTH) begin
			placed_list[placed_num] = p;
			placed_num++;
		end else begin
			dropped = 1;
		end
		drop_free(bi);
		if (f.w > sw) add_free('{f.x + (p.x == f.x ? sw : 0), f.y, f.w - sw, f.h});
		if (f.h > sh) add_free('{f.x, f.y + sh, f.w, f.h - sh});
		i = 0;
		while (i < free_num) begin
			q = free_list[i];
			if (!boxes_overlap(q, p)) begin
				i++;
				continue;
			end
			drop_free(i);
			if (p.x + p.w < q.x + q.w) add_free('{p.x + p.w, q.y, q.x + q.w - p.x - p.w, q.h});
			if (p.y + p.h < q.y + q.h) add_free('{q.x, p.y + p.h, q.w, q.y + q.h - p.y - p.h});
			if (p.x > q.x) add_free('{q.x, q.y, p.x - q.x, q.h});
			if (p.y > q.y) add_free('{q.x, q.y, q.w, p.y - q.y});
		end
		i = 0;
		while (i < free_num) begin
			j = i + 1;
			gone = 0;
			while (j < free_num) begin
				if (box_holds(free_list[j], free_list[i])) begin
					drop_free(i);
					gone = 1;
					break;
				end
				if (box_holds(free_list[i], free_list[j])) drop_free(j);
				else j++;
			end
			if (!gone) i++;
		end
		o.status = ST_PLACED;
		o.pos_x = p.x[15:0];
		o.pos_y = p.y[15:0];
		o.was_rotated = brot;
		o.overflow = dropped;
		return o;
	endfunction

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_BIN_W: bin_w = val;
			REG_BIN_H: bin_h = val;
			REG_HEUR: heur = val[2:0];
			REG_ROT: rot_en = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (placement_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one request, optional expected value typed in by hand
	task automatic send_req(req_t rq, bit fixed, rsp_t exp);
		rsp_t pred;
		if (send_busy_mode) repeat ($urandom_range(0, 17)) @(negedge clk);
		req_valid = 1;
		req = rq;
		do @(posedge clk); while (!(req_valid && req_ready));
		pred = pack_piece(rq);
		if (fixed && pred != exp) begin
			$error("table row disagrees with model for w=%0d h=%0d", rq.rect_width,
				rq.rect_height);
			errors++;
		end
		placement_q.push_back(fixed ? exp : pred);
		sent++;
		@(negedge clk);
		req_valid = 0;
	endtask

	function automatic logic [15:0] pick_size(int unsigned lim);
		int unsigned c;
		c = $urandom_range(0, 99);
		if (c < 3) return 16'd0;
		if (c < 6) return 16'($urandom);
		if (c < 7) return 16'hFFFF;
		if (c < 20) return 16'($urandom_range(1, lim > 0 ? lim : 1));
		return 16'($urandom_range(1, lim / 4 > 0 ? lim / 4 : 1));
	endfunction

	function automatic logic [15:0] pick_bin();
		case ($urandom_range(0, 7))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return BIN_RESET;
			3: return 16'($urandom);
			default: return 16'($urandom_range(4, 400));
		endcase
	endfunction

	// results side
	initial begin
		rsp_t want;
		rsp_ready = 0;
		forever begin
			@(negedge clk);
			rsp_ready = 0;
			if (recv_busy_mode) repeat ($urandom_range(0, 17)) @(negedge clk);
			rsp_ready = 1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			if (placement_q.size() == 0) begin
				$error("unexpected result: status=%0d", rsp.status);
				errors++;
			end else begin
				want = placement_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.pos_x !== want.pos_x) begin
					$error("pos_x: expected %0d actual %0d", want.pos_x, rsp.pos_x);
					errors++;
				end
				if (rsp.pos_y !== want.pos_y) begin
					$error("pos_y: expected %0d actual %0d", want.pos_y, rsp.pos_y);
					errors++;
				end
				if (rsp.was_rotated !== want.was_rotated) begin
					$error("was_rotated: expected %0d actual %0d", want.was_rotated,
						rsp.was_rotated);
					errors++;
				end
				if (rsp.overflow !== want.overflow) begin
					$error("overflow: expected %0d actual %0d", want.overflow, rsp.overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (10) #1_000_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		row_t rows[$];
		rsp_t none;
		rsp_t zero_piece;
		rsp_t no_fit;
		req_t rq;
		int unsigned phase, n, lim;
		none = '0;
		zero_piece = '0;
		zero_piece.status = ST_ZERO;
		no_fit = '0;
		no_fit.status = ST_NOFIT;
		no_fit.pos_x = '1;
		no_fit.pos_y = '1;
		rows = '{
			'{1'b1, 16'd0, 16'd5, 1'b1, zero_piece},
			'{1'b1, 16'd5, 16'd0, 1'b1, zero_piece},
			'{1'b1, 16'd2000, 16'd10, 1'b1, no_fit},
			'{1'b1, 16'd1024, 16'd1024, 1'b1, none},
			'{1'b1, 16'd1, 16'd1, 1'b1, no_fit},
			'{CMD_START, 16'hFFFF, 16'hFFFF, 1'b1, none},
			'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, no_fit},
			'{1'b1, 16'd10, 16'd2000, 1'b1, no_fit},
			'{1'b1, 16'd1024, 16'd512, 1'b0, none},
			'{1'b1, 16'd1024, 16'd512, 1'b0, none},
			'{CMD_START, 16'd0, 16'd0, 1'b1, none},
			'{1'b1, 16'd1000, 16'd1024, 1'b0, none},
			'{1'b1, 16'd1024, 16'd24, 1'b0, none},
			'{1'b1, 16'd1, 16'd1, 1'b0, none},
			'{CMD_START, 16'd0, 16'd0, 1'b1, none},
			'{1'b1, 16'd1, 16'd1024, 1'b0, none},
			'{1'b1, 16'd1023, 16'd1, 1'b0, none}
		};
		clk = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = REG_BIN_W;
		cfg_data = '0;
		errors = 0;
		sent = 0;
		send_busy_mode = 1;
		recv_busy_mode = 1;
		bin_w = BIN_RESET;
		bin_h = BIN_RESET;
		heur = HEUR_RESET;
		rot_en = ROT_RESET;
		open_bin();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[k]) begin
			rq.cmd = rows[k].cmd;
			rq.rect_width = rows[k].w;
			rq.rect_height = rows[k].h;
			send_req(rq, rows[k].fixed, rows[k].exp);
		end

		phase = 0;
		while (sent < TOTAL_REQS) begin
			// idle before any register write
			drain();
			write_reg(REG_BIN_W, pick_bin());
			write_reg(REG_BIN_H, pick_bin());
			write_reg(REG_HEUR, DATA_BITS'(phase < 8 ? phase : $urandom_range(0, 7)));
			write_reg(REG_ROT, DATA_BITS'(phase % 2));
			send_busy_mode = ($urandom_range(0, 3) != 0);
			recv_busy_mode = ($urandom_range(0, 3) != 0);
			lim = bin_w < bin_h ? bin_w : bin_h;
			n = $urandom_range(10, 110);
			rq = '0;
			rq.cmd = CMD_START;
			send_req(rq, 0, none);
			repeat (n) begin
				rq.cmd = ($urandom_range(0, 29) == 0) ? CMD_START : 1'b1;
				rq.rect_width = pick_size(lim);
				rq.rect_height = pick_size(lim);
				send_req(rq, 0, none);
			end
			phase++;
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && placement_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
